@@ sv/hpq_pkg.sv @@
// Shared constants, codes and types for the max-heap priority queue.
package hpq_pkg;

  // Storage geometry
  localparam int CAPACITY  = 32;
  localparam int KEY_WIDTH = 16;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  // Child index may reach 2*CAPACITY, one bit more than a count
  localparam int CIDX_W    = ADDR_W + 2;

  // Stream widths, tdata padded to whole bytes
  localparam int IN_TDATA_W  = ((KEY_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((KEY_WIDTH + CNT_W + 7) / 8) * 8;
  localparam int STAT_W      = 2;

  // Operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Result handed from the sift engine to the output stage
  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [STAT_W-1:0]    status;
    logic [CNT_W-1:0]     count;
  } res_t;

endpackage

@@ sv/hpq_core.sv @@
// Heap store and sift sequencer: one compare/move step per cycle.
module hpq_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            op_valid,
  output logic                            op_ready,
  input  logic                            op,
  input  logic [hpq_pkg::KEY_WIDTH-1:0]   key_in,
  output logic                            res_valid,
  input  logic                            res_ready,
  output hpq_pkg::res_t                   res
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UP   = 6'b000010,
    S_EXLD = 6'b000100,
    S_DN   = 6'b001000,
    S_PUT  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  localparam int AW = hpq_pkg::ADDR_W;
  localparam int KW = hpq_pkg::KEY_WIDTH;
  localparam int CW = hpq_pkg::CNT_W;
  localparam int XW = hpq_pkg::CIDX_W;

  state_t                       state_r, state_nxt;
  logic [AW-1:0]                pos_r, pos_nxt;
  logic [KW-1:0]                key_r, key_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [KW-1:0]                kout_r, kout_nxt;
  logic [hpq_pkg::STAT_W-1:0]   stat_r, stat_nxt;

  // Heap store: one write port, two registered read ports
  logic [KW-1:0] mem [hpq_pkg::CAPACITY];
  logic          we;
  logic [AW-1:0] waddr, raddr0, raddr1;
  logic [KW-1:0] wdata, rdata0, rdata1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    logic [AW-1:0] d;
    d = p - AW'(1);
    return d >> 1;
  endfunction

  // Sift-down candidates at the hole position
  logic [XW-1:0] lc, rc, n_ext, best_idx, best_lc;
  logic [KW-1:0] best_val;
  logic          best_is_pos;
  logic [AW-1:0] par, par_par;

  always_comb begin
    par      = parent_of(pos_r);
    par_par  = parent_of(par);
    lc       = XW'({pos_r, 1'b1});
    rc       = lc + XW'(1);
    n_ext    = XW'(cnt_r);
    best_idx = XW'(pos_r);
    best_val = key_r;
    best_is_pos = 1'b1;
    // left wins ties, the moving key wins ties over both children
    if (rdata0 > key_r) begin
      best_idx    = lc;
      best_val    = rdata0;
      best_is_pos = 1'b0;
    end
    if ((rc < n_ext) && (rdata1 > best_val)) begin
      best_idx    = rc;
      best_val    = rdata1;
      best_is_pos = 1'b0;
    end
    best_lc = XW'({best_idx[AW-1:0], 1'b1});
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    kout_nxt  = kout_r;
    stat_nxt  = stat_r;
    we        = 1'b0;
    waddr     = pos_r;
    wdata     = key_r;
    raddr0    = '0;
    raddr1    = '0;
    op_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        op_ready = 1'b1;
        if (op_valid) begin
          key_nxt  = key_in;
          kout_nxt = '0;
          stat_nxt = hpq_pkg::ST_OK;
          if (op == hpq_pkg::OP_INSERT) begin
            if (cnt_r == CW'(hpq_pkg::CAPACITY)) begin
              stat_nxt  = hpq_pkg::ST_FULL;
              state_nxt = S_FIN;
            end else begin
              pos_nxt = cnt_r[AW-1:0];
              cnt_nxt = cnt_r + CW'(1);
              if (cnt_r == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = key_in;
                state_nxt = S_FIN;
              end else begin
                raddr0    = parent_of(cnt_r[AW-1:0]);
                state_nxt = S_UP;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              stat_nxt  = hpq_pkg::ST_EMPTY;
              state_nxt = S_FIN;
            end else begin
              raddr0    = '0;
              raddr1    = AW'(cnt_r - CW'(1));
              cnt_nxt   = cnt_r - CW'(1);
              state_nxt = S_EXLD;
            end
          end
        end
      end
      // Insert: move a smaller parent down into the hole
      S_UP: begin
        we = 1'b1;
        if (rdata0 < key_r) begin
          wdata   = rdata0;
          pos_nxt = par;
          if (par == '0) begin
            state_nxt = S_PUT;
          end else begin
            raddr0 = par_par;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      // Extract: root leaves, last entry becomes the moving key
      S_EXLD: begin
        kout_nxt = rdata0;
        key_nxt  = rdata1;
        pos_nxt  = '0;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else if (cnt_r == CW'(1)) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = rdata1;
          state_nxt = S_FIN;
        end else begin
          raddr0    = AW'(1);
          raddr1    = AW'(2);
          state_nxt = S_DN;
        end
      end
      // Extract: pull the larger child up into the hole
      S_DN: begin
        we = 1'b1;
        if (best_is_pos) begin
          state_nxt = S_FIN;
        end else begin
          wdata   = best_val;
          pos_nxt = best_idx[AW-1:0];
          if (best_lc >= n_ext) begin
            state_nxt = S_PUT;
          end else begin
            raddr0 = best_lc[AW-1:0];
            raddr1 = AW'(best_lc + XW'(1));
          end
        end
      end
      S_PUT: begin
        we        = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    key_r  <= key_nxt;
    kout_r <= kout_nxt;
    stat_r <= stat_nxt;
  end

  assign res.key    = kout_r;
  assign res.status = stat_r;
  assign res.count  = cnt_r;

endmodule

@@ sv/max_heap_priority_queue_top.sv @@
// Top level of the max-heap priority queue: stream ports and output register.
//
// Input channel (in_*): in_tuser is the operation (0 insert, 1 extract the
// maximum), in_tdata carries the key to insert. A transaction is taken when
// in_tvalid and in_tready are both high.
// Result channel (out_*): one transaction per input transaction, in order.
// out_tdata holds the extracted key (zero unless an extract succeeded) and
// the key count after the operation; out_tuser holds the status (0 ok,
// 1 insert refused because full, 2 extract refused because empty).
// Timing: one item is worked at a time by a sift sequencer that does one
// compare and one store move per cycle over a two-read, one-write heap RAM.
// The key moves at most 5 levels on an insert and at most 4 on an extract,
// since at most 31 keys stay. in_tready is high only while the sequencer idles.
// A finished result sits in the output register, so the next input may be
// accepted while it waits; a second result waits in the sequencer until the
// register frees. Reset (rst_n low, synchronous) empties the heap and drops
// any pending result; the heap RAM itself is not cleared.
module max_heap_priority_queue_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hpq_pkg::IN_TDATA_W-1:0]     in_tdata,   // [15:0] key_in
  input  logic                               in_tuser,   // [0] op
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hpq_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [15:0] key_out, [21:16] count_out
  output logic [hpq_pkg::STAT_W-1:0]         out_tuser   // [1:0] status
);

  logic           res_valid, res_ready;
  hpq_pkg::res_t  res;
  logic           out_tvalid_r, out_tvalid_nxt;
  hpq_pkg::res_t  out_res_r;

  hpq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (in_tvalid),
    .op_ready  (in_tready),
    .op        (in_tuser),
    .key_in    (in_tdata[hpq_pkg::KEY_WIDTH-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register takes a result when empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = hpq_pkg::OUT_TDATA_W'({out_res_r.count, out_res_r.key});
  assign out_tuser  = out_res_r.status;

endmodule

@@ sv/hpq_checker.sv @@
// Port-level checks for the max-heap priority queue, bound to the top level.
module hpq_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [hpq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic [hpq_pkg::STAT_W-1:0]         out_tuser
);

  localparam int KW = hpq_pkg::KEY_WIDTH;
  localparam int CW = hpq_pkg::CNT_W;

  // A full refusal only happens at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == hpq_pkg::ST_FULL) |->
      (out_tdata[KW+CW-1:KW] == CW'(hpq_pkg::CAPACITY)))
    else $error("full status with count below capacity");

  // An empty refusal reports no keys and a zero key
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == hpq_pkg::ST_EMPTY) |->
      (out_tdata[KW+CW-1:KW] == '0 && out_tdata[KW-1:0] == '0))
    else $error("empty status with nonzero count or key");

  // Status code is never the unused value
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == hpq_pkg::ST_OK || out_tuser == hpq_pkg::ST_FULL ||
                    out_tuser == hpq_pkg::ST_EMPTY))
    else $error("undefined status code");

  // In the cycle after taking an item the block is busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready right after an accepted transaction");

  // A shown result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule

bind max_heap_priority_queue_top hpq_checker u_hpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the max-heap priority queue: predicted heap order vs stream results.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hpq_pkg::*;

  // Predicts each result from a private copy of the heap and checks the outputs in order
  class heap_order_checker;
    logic [KEY_WIDTH-1:0] keys [CAPACITY];
    int unsigned held;
    res_t pending_results[$];
    int mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void swap_keys(int unsigned a, int unsigned b);
      logic [KEY_WIDTH-1:0] tmp;
      tmp = keys[a];
      keys[a] = keys[b];
      keys[b] = tmp;
    endfunction

    // Apply one operation to the model heap and return the result it should produce
    function res_t apply_op(logic op, logic [KEY_WIDTH-1:0] key);
      res_t r;
      int unsigned pos;
      int unsigned parent;
      int unsigned best;
      int unsigned left;
      int unsigned right;
      bit moving;
      r.key = '0;
      r.status = ST_OK;
      if (op == OP_INSERT) begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = held;
          keys[pos] = key;
          held++;
          // sift up past strictly smaller parents only
          moving = 1'b1;
          while (moving && pos > 0) begin
            parent = (pos - 1) / 2;
            if (keys[parent] < keys[pos]) begin
              swap_keys(parent, pos);
              pos = parent;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end else begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.key = keys[0];
          held--;
          keys[0] = keys[held];
          // sift down toward the larger child, left wins a tie
          pos = 0;
          moving = 1'b1;
          while (moving) begin
            best = pos;
            left = 2 * pos + 1;
            right = 2 * pos + 2;
            if (left < held && keys[left] > keys[best]) best = left;
            if (right < held && keys[right] > keys[best]) best = right;
            if (best == pos) begin
              moving = 1'b0;
            end else begin
              swap_keys(pos, best);
              pos = best;
            end
          end
        end
      end
      r.count = CNT_W'(held);
      return r;
    endfunction

    function void note_request(logic op, logic [KEY_WIDTH-1:0] key);
      pending_results.push_back(apply_op(op, key));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: key_out %0d status %0d count_out %0d",
               got.key, got.status, got.count);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.key !== want.key) begin
        $error("key_out mismatch: expected %0d, actual %0d", want.key, got.key);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count_out mismatch: expected %0d, actual %0d", want.count, got.count);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [15:0] key_in
  logic                   in_tuser = 1'b0; // [0] op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [15:0] key_out, [21:16] count_out
  logic [STAT_W-1:0]      out_tuser;       // [1:0] status

  heap_order_checker queue_model = new();
  bit          tx_idles = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_cycle = 0;

  always #10 clk = ~clk;

  max_heap_priority_queue_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Offer one operation and wait until the block takes it
  task automatic send_op(input logic op, input logic [KEY_WIDTH-1:0] key);
    @(negedge clk);
    while (tx_idles && $urandom_range(99) < 11) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = IN_TDATA_W'(key);
    do @(posedge clk); while (!in_tready);
    queue_model.note_request(op, key);
  endtask

  // Stop offering until every predicted result has come back
  task automatic drain_wait();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (queue_model.pending() != 0) @(negedge clk);
  endtask

  // Receiver back-pressure: random stalls, one quiet window, and requested long hold-offs
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else if (rx_cycle >= 6000 && rx_cycle < 9000) begin
      out_tready = 1'b1;
    end else begin
      out_tready = ($urandom_range(99) >= 11);
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.key    = out_tdata[KEY_WIDTH-1:0];
      got.count  = out_tdata[KEY_WIDTH +: CNT_W];
      got.status = out_tuser;
      queue_model.check_result(got);
    end
  end

  // Stimulus
  initial begin
    int unsigned bias;
    int unsigned sel;
    logic op;
    logic [KEY_WIDTH-1:0] key;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // extract from an empty heap, extremes, equal keys, then drain past empty
    send_op(OP_EXTRACT, 16'hFFFF);
    send_op(OP_INSERT, 16'h0000);
    send_op(OP_INSERT, 16'hFFFF);
    send_op(OP_INSERT, 16'h8000);
    send_op(OP_INSERT, 16'h7FFF);
    send_op(OP_INSERT, 16'h0001);
    send_op(OP_INSERT, 16'h0005);
    send_op(OP_INSERT, 16'h0005);
    send_op(OP_INSERT, 16'h0005);
    send_op(OP_INSERT, 16'hFFFF);
    repeat (10) send_op(OP_EXTRACT, 16'h5A5A);
    send_op(OP_INSERT, 16'hAAAA);
    send_op(OP_INSERT, 16'h5555);
    drain_wait();

    // Random part: insert-heavy, balanced and extract-heavy phases of 50 transactions,
    // so the heap runs full and empty repeatedly
    for (int i = 0; i < 1230; i++) begin
      case ((i / 50) % 3)
        0:       bias = 85;
        1:       bias = 50;
        default: bias = 15;
      endcase
      tx_idles = !(i >= 600 && i < 800);
      if (i == 300 || i == 1000) hold_req = 1'b1;
      if (i == 700) drain_wait();
      op  = ($urandom_range(99) < bias) ? OP_INSERT : OP_EXTRACT;
      sel = $urandom_range(9);
      if (sel < 5)       key = KEY_WIDTH'($urandom);
      else if (sel < 8)  key = KEY_WIDTH'($urandom_range(7));
      else if (sel == 8) key = '1;
      else               key = '0;
      send_op(op, key);
    end

    // Let the last results arrive, then watch for strays
    @(negedge clk);
    in_tvalid = 1'b0;
    while (queue_model.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (queue_model.mismatches == 0 && queue_model.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/hpq_pkg.sv
sv/hpq_core.sv
sv/max_heap_priority_queue_top.sv
sv/hpq_checker.sv
tb/sv/tb_top.sv
